[sv/dss_pkg.sv]
// Shared constants, types and state codes of the disk seek scheduler.
`timescale 1ns / 1ps

package dss_pkg;

  localparam int MAX_REQUESTS = 16;
  localparam int CYL_W        = 16;
  localparam int TOTAL_W      = 21;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  // Sorted list holds the requests plus the head and, in C-SCAN, both disk ends.
  localparam int SRT_DEPTH = MAX_REQUESTS + 3;
  localparam int SRT_AW    = $clog2(SRT_DEPTH);
  localparam int SIDX_W    = $clog2(SRT_DEPTH + 1);
  localparam int CNT_W     = $clog2(MAX_REQUESTS + 1);
  localparam int RIDX_W    = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  typedef logic [CYL_W-1:0]   cyl_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [SIDX_W-1:0]  sidx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Register indexes (byte address / 4).
  localparam logic [1:0] REG_ALGORITHM     = 2'd0;
  localparam logic [1:0] REG_HEAD_POSITION = 2'd1;
  localparam logic [1:0] REG_DISK_SIZE     = 2'd2;

  // Scheduling modes; the unused code behaves as FCFS.
  localparam logic [1:0] ALG_CSCAN = 2'd0;
  localparam logic [1:0] ALG_SCAN  = 2'd1;
  localparam logic [1:0] ALG_FCFS  = 2'd2;

  localparam logic [16:0] DISK_SIZE_RESET = 17'd200;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_LOAD,
    S_INS,
    S_FIND,
    S_FETCH,
    S_MOVE,
    S_WAIT
  } dss_state_t;

  typedef enum logic {
    PH_UP,
    PH_DOWN
  } sweep_phase_t;

endpackage

[sv/disk_seek_scheduler.sv]
// Disk seek scheduler: request store, insertion sort and movement sequencer.
`timescale 1ns / 1ps

// Requests are collected one per cycle; the request flagged last closes the batch
// and the block stalls its input until every movement has been taken. All compares,
// clamps and distances go through one 16-bit subtract unit. In FCFS each stored
// request becomes one movement. In C-SCAN and SCAN the batch is first sorted by
// insertion together with the head (and, in C-SCAN, cylinder 0 and the last
// cylinder): each entry is loaded, then compared against the sorted entries with
// larger ones shifted up, and the sorted list is then scanned to locate the head.
// Each movement then goes through fetch target, compute and present, held while
// the output is stalled. A request arriving while the store is full is dropped.
module disk_seek_scheduler
  import dss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_request_cylinder,
  input  logic              in_last_request,
  // movement channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_move_from,
  output logic [15:0]       out_move_to,
  output logic [15:0]       out_move_distance,
  output logic [20:0]       out_total_seek,
  output logic              out_last_move,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  dss_state_t   state_r, state_nxt;

  logic [1:0]   algorithm_r;
  cyl_t         head_position_r;
  logic [16:0]  disk_size_r;

  cnt_t         cnt_r, cnt_nxt;
  cnt_t         n_r, n_nxt;
  cyl_t         req_r [MAX_REQUESTS];
  cyl_t         srt_r [SRT_DEPTH];

  cyl_t         lastc_r, lastc_nxt;
  cyl_t         head_r, head_nxt;
  cyl_t         cur_r, cur_nxt;
  cyl_t         t_r, t_nxt;
  cyl_t         v_r, v_nxt;
  sidx_t        m_r, m_nxt;
  sidx_t        k_r, k_nxt;
  sidx_t        j_r, j_nxt;
  sidx_t        len_r, len_nxt;
  sidx_t        idx_r, idx_nxt;
  sidx_t        dn_r, dn_nxt;
  sidx_t        tot_r, tot_nxt;
  sidx_t        mv_r, mv_nxt;
  sweep_phase_t ph_r, ph_nxt;
  logic         hit_top_r, hit_top_nxt;
  total_t       seek_r, seek_nxt;

  logic         out_valid_r, out_valid_nxt;
  cyl_t         out_from_r, out_from_nxt;
  cyl_t         out_to_r, out_to_nxt;
  cyl_t         out_dist_r, out_dist_nxt;
  total_t       out_total_r, out_total_nxt;
  logic         out_last_r, out_last_nxt;

  // Shared subtract unit.
  cyl_t         alu_a, alu_b;
  logic [16:0]  alu_diff;
  logic         alu_borrow, alu_eq, alu_gt;
  cyl_t         alu_abs;

  logic         in_acc;
  logic         is_cscan, is_scan, is_fcfs;
  logic         store_room;
  cyl_t         lastc_calc;
  sidx_t        sched_tot;
  logic         ins_done;
  logic         req_we;
  logic [RIDX_W-1:0] req_ra;
  cyl_t         req_rd;
  sidx_t        srt_ra;
  cyl_t         srt_rd;
  logic         srt_we;
  sidx_t        srt_wa;
  cyl_t         srt_wd;
  cyl_t         ld_src;
  cyl_t         tsrc;
  logic [TOTAL_W:0] seek_sum;

  assign in_acc     = in_valid && !in_stall;
  assign is_cscan   = (algorithm_r == ALG_CSCAN);
  assign is_scan    = (algorithm_r == ALG_SCAN);
  assign is_fcfs    = !is_cscan && !is_scan;
  assign store_room = (cnt_r < cnt_t'(MAX_REQUESTS));

  // Zero cylinders is treated as one; anything above 65536 as 65536.
  always_comb begin
    if (disk_size_r == 17'd0) begin
      lastc_calc = '0;
    end else if (disk_size_r[16]) begin
      lastc_calc = '1;
    end else begin
      lastc_calc = disk_size_r[15:0] - cyl_t'(1);
    end
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[16];
  assign alu_eq     = (alu_diff[15:0] == '0);
  assign alu_gt     = !alu_borrow && !alu_eq;
  assign alu_abs    = alu_borrow ? (~alu_diff[15:0] + cyl_t'(1)) : alu_diff[15:0];

  assign req_rd = req_r[req_ra];
  assign srt_rd = srt_r[srt_ra[SRT_AW-1:0]];

  assign ins_done = (j_r == '0) || !alu_gt;

  // Number of movements of the batch, known once the head has been located.
  always_comb begin
    if (is_fcfs) begin
      sched_tot = sidx_t'(n_r);
    end else if (is_cscan) begin
      sched_tot = m_r - sidx_t'(1);
    end else begin
      sched_tot = m_r - sidx_t'(1) + sidx_t'(!hit_top_r);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_last_request) state_nxt = S_HEAD;
      end
      S_HEAD: begin
        if (!is_fcfs) begin
          state_nxt = S_LOAD;
        end else if (n_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_LOAD: state_nxt = S_INS;
      S_INS: begin
        if (ins_done) begin
          state_nxt = (k_r + sidx_t'(1) == m_r) ? S_FIND : S_LOAD;
        end
      end
      S_FIND: begin
        if (alu_eq) state_nxt = (sched_tot == '0) ? S_IDLE : S_FETCH;
      end
      S_FETCH: state_nxt = S_MOVE;
      S_MOVE:  state_nxt = S_WAIT;
      S_WAIT: begin
        if (!out_stall) state_nxt = out_last_r ? S_IDLE : S_FETCH;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    lastc_nxt     = lastc_r;
    head_nxt      = head_r;
    cur_nxt       = cur_r;
    t_nxt         = t_r;
    v_nxt         = v_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    dn_nxt        = dn_r;
    tot_nxt       = tot_r;
    mv_nxt        = mv_r;
    ph_nxt        = ph_r;
    hit_top_nxt   = hit_top_r;
    seek_nxt      = seek_r;
    out_valid_nxt = out_valid_r;
    out_from_nxt  = out_from_r;
    out_to_nxt    = out_to_r;
    out_dist_nxt  = out_dist_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;
    alu_a         = '0;
    alu_b         = '0;
    req_we        = 1'b0;
    req_ra        = idx_r[RIDX_W-1:0];
    srt_ra        = '0;
    srt_we        = 1'b0;
    srt_wa        = j_r;
    srt_wd        = v_r;
    ld_src        = lastc_r;
    tsrc          = '0;
    seek_sum      = '0;
    in_stall      = 1'b1;

    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_acc) begin
          if (store_room) begin
            req_we  = 1'b1;
            cnt_nxt = cnt_r + cnt_t'(1);
          end
          if (in_last_request) begin
            n_nxt     = store_room ? cnt_r + cnt_t'(1) : cnt_r;
            cnt_nxt   = '0;
            lastc_nxt = lastc_calc;
          end
        end
      end
      S_HEAD: begin
        alu_a       = head_position_r;
        alu_b       = lastc_r;
        head_nxt    = alu_gt ? lastc_r : head_position_r;
        cur_nxt     = head_nxt;
        seek_nxt    = '0;
        mv_nxt      = '0;
        idx_nxt     = '0;
        k_nxt       = '0;
        len_nxt     = '0;
        hit_top_nxt = 1'b0;
        tot_nxt     = sidx_t'(n_r);
        m_nxt       = sidx_t'(n_r) + (is_cscan ? sidx_t'(3) : sidx_t'(1));
      end
      S_LOAD: begin
        // List order: stored requests, the head, then cylinder 0 and the last cylinder.
        req_ra = k_r[RIDX_W-1:0];
        if (k_r < sidx_t'(n_r)) begin
          ld_src = req_rd;
        end else if (k_r == sidx_t'(n_r)) begin
          ld_src = head_r;
        end else if (k_r == sidx_t'(n_r) + sidx_t'(1)) begin
          ld_src = '0;
        end else begin
          ld_src = lastc_r;
        end
        alu_a       = ld_src;
        alu_b       = lastc_r;
        v_nxt       = alu_gt ? lastc_r : ld_src;
        hit_top_nxt = hit_top_r | !alu_borrow;
        j_nxt       = len_r;
      end
      S_INS: begin
        srt_ra = (j_r == '0) ? sidx_t'(0) : j_r - sidx_t'(1);
        alu_a  = srt_rd;
        alu_b  = v_r;
        srt_we = 1'b1;
        srt_wa = j_r;
        if (!ins_done) begin
          srt_wd = srt_rd;
          j_nxt  = j_r - sidx_t'(1);
        end else begin
          srt_wd  = v_r;
          len_nxt = len_r + sidx_t'(1);
          k_nxt   = k_r + sidx_t'(1);
          idx_nxt = '0;
        end
      end
      S_FIND: begin
        srt_ra = idx_r;
        alu_a  = srt_rd;
        alu_b  = head_r;
        if (alu_eq) begin
          tot_nxt = sched_tot;
          dn_nxt  = idx_r - sidx_t'(1);
          ph_nxt  = PH_UP;
          if (is_cscan && (idx_r + sidx_t'(1) == m_r)) begin
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + sidx_t'(1);
          end
        end else begin
          idx_nxt = idx_r + sidx_t'(1);
        end
      end
      S_FETCH: begin
        if (is_fcfs) begin
          tsrc    = req_rd;
          idx_nxt = idx_r + sidx_t'(1);
        end else if (is_cscan) begin
          // C-SCAN walks the sorted list circularly from just above the head.
          srt_ra  = idx_r;
          tsrc    = srt_rd;
          idx_nxt = (idx_r + sidx_t'(1) == m_r) ? sidx_t'(0) : idx_r + sidx_t'(1);
        end else if (ph_r == PH_UP && idx_r != m_r) begin
          srt_ra  = idx_r;
          tsrc    = srt_rd;
          idx_nxt = idx_r + sidx_t'(1);
        end else if (ph_r == PH_UP && !hit_top_r) begin
          // The upward sweep ends on the last cylinder even without a request there.
          tsrc   = lastc_r;
          ph_nxt = PH_DOWN;
        end else begin
          srt_ra = dn_r;
          tsrc   = srt_rd;
          dn_nxt = dn_r - sidx_t'(1);
          ph_nxt = PH_DOWN;
        end
        alu_a = tsrc;
        alu_b = lastc_r;
        t_nxt = alu_gt ? lastc_r : tsrc;
      end
      S_MOVE: begin
        alu_a         = cur_r;
        alu_b         = t_r;
        seek_sum      = {1'b0, seek_r} + (TOTAL_W + 1)'(alu_abs);
        seek_nxt      = seek_sum[TOTAL_W] ? '1 : seek_sum[TOTAL_W-1:0];
        out_from_nxt  = cur_r;
        out_to_nxt    = t_r;
        out_dist_nxt  = alu_abs;
        out_total_nxt = seek_nxt;
        out_last_nxt  = (mv_r + sidx_t'(1) == tot_r);
        out_valid_nxt = 1'b1;
        cur_nxt       = t_r;
        mv_nxt        = mv_r + sidx_t'(1);
      end
      S_WAIT: begin
        if (!out_stall) out_valid_nxt = 1'b0;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
      seek_r          <= '0;
      algorithm_r     <= ALG_CSCAN;
      head_position_r <= '0;
      disk_size_r     <= DISK_SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      seek_r      <= seek_nxt;
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_ALGORITHM:     algorithm_r     <= pwdata[1:0];
          REG_HEAD_POSITION: head_position_r <= pwdata[15:0];
          REG_DISK_SIZE:     disk_size_r     <= pwdata[16:0];
          default: ;
        endcase
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (req_we) req_r[cnt_r[RIDX_W-1:0]] <= in_request_cylinder;
    if (srt_we) srt_r[srt_wa[SRT_AW-1:0]] <= srt_wd;
    n_r         <= n_nxt;
    lastc_r     <= lastc_nxt;
    head_r      <= head_nxt;
    cur_r       <= cur_nxt;
    t_r         <= t_nxt;
    v_r         <= v_nxt;
    m_r         <= m_nxt;
    k_r         <= k_nxt;
    j_r         <= j_nxt;
    len_r       <= len_nxt;
    idx_r       <= idx_nxt;
    dn_r        <= dn_nxt;
    tot_r       <= tot_nxt;
    mv_r        <= mv_nxt;
    ph_r        <= ph_nxt;
    hit_top_r   <= hit_top_nxt;
    out_from_r  <= out_from_nxt;
    out_to_r    <= out_to_nxt;
    out_dist_r  <= out_dist_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    case (paddr[3:2])
      REG_ALGORITHM:     prdata = DATA_W'(algorithm_r);
      REG_HEAD_POSITION: prdata = DATA_W'(head_position_r);
      REG_DISK_SIZE:     prdata = DATA_W'(disk_size_r);
      default:           prdata = '0;
    endcase
  end

  assign pready            = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_move_from     = out_from_r;
  assign out_move_to       = out_to_r;
  assign out_move_distance = out_dist_r;
  assign out_total_seek    = out_total_r;
  assign out_last_move     = out_last_r;

  // A movement is only presented while the sequencer waits for it to be taken.
  a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_WAIT))
    else $error("movement presented outside the wait state");

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(MAX_REQUESTS))
    else $error("request count beyond store depth");

  // The final movement being taken must return the block to request intake.
  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_move) |=> !in_stall)
    else $error("input still stalled after final movement");

  a_move_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> (mv_r < tot_r))
    else $error("movement emitted beyond the batch count");

  a_insert_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (j_r <= len_r && len_r < m_r))
    else $error("insertion index outside sorted list");

endmodule
